// ===== rtl/rdc_pkg.sv =====
// shared types, constants and helper functions for the radix digit converter
// no dependencies; used by every rtl file of the block but rdc_queue
package rdc_pkg;

    localparam int VALUE_W  = 31;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 4;
    localparam int RECIP_W  = 32;
    localparam int PROD_W   = VALUE_W + RECIP_W;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 4'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 4'd2;

    // register index of the radix register (paddr[2])
    localparam logic REG_RADIX = 1'b0;

    typedef struct packed {
        logic               group_mark;
        logic [DIGIT_W-1:0] digit;
    } rdc_digit_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_FIX,
        F_PUSH
    } rdc_front_state_t;

    // clamp the raw register value to the supported bases
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] b;
        if (r < RADIX_MIN) begin
            b = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            b = RADIX_MAX;
        end else begin
            b = r;
        end
        return b;
    endfunction

    // floor(2^32 / base); the estimate from it is low by at most one
    function automatic logic [RECIP_W-1:0] recip(input logic [RADIX_W-1:0] b);
        logic [RECIP_W-1:0] m;
        case (b)
            4'd2: begin
                m = 32'h8000_0000;
            end
            4'd3: begin
                m = 32'h5555_5555;
            end
            4'd4: begin
                m = 32'h4000_0000;
            end
            4'd5: begin
                m = 32'h3333_3333;
            end
            4'd6: begin
                m = 32'h2AAA_AAAA;
            end
            4'd7: begin
                m = 32'h2492_4924;
            end
            4'd8: begin
                m = 32'h2000_0000;
            end
            4'd9: begin
                m = 32'h1C71_C71C;
            end
            4'd10: begin
                m = 32'h1999_9999;
            end
            default: begin
                m = 32'h8000_0000;
            end
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/rdc_front.sv =====
// front end: accepts a value and converts it to digits, one multiply state and one correction state per digit
// depends on rdc_pkg
module rdc_front #(
    parameter int MAX_DIGITS = 32,
    parameter int GROUP_SIZE = 4,
    localparam int CW    = $clog2(MAX_DIGITS + 1),
    localparam int DG_W  = $bits(rdc_pkg::rdc_digit_t),
    localparam int VEC_W = MAX_DIGITS * DG_W
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [rdc_pkg::VALUE_W-1:0]      in_value,
    input  logic [rdc_pkg::RADIX_W-1:0]      radix,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [CW-1:0]                    out_count,
    output logic [VEC_W-1:0]                 out_digits
);

    localparam int VW = rdc_pkg::VALUE_W;
    localparam int RW = rdc_pkg::RADIX_W;
    localparam int PW = $clog2(GROUP_SIZE);

    rdc_pkg::rdc_front_state_t state_reg, state_next;
    logic [VW-1:0]              v_reg, v_next;
    logic [RW-1:0]              base_reg, base_next;
    logic [rdc_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [CW-1:0]              n_reg, n_next;
    logic [PW-1:0]              phase_reg, phase_next;
    logic [VEC_W-1:0]           vec_reg, vec_next;

    logic [VW-1:0]    q_est;
    logic [VW+RW-1:0] qb;
    logic [VW+RW-1:0] r_full;
    logic [RW:0]      rem5;
    logic [RW:0]      dig5;
    logic             fix;
    logic [VW-1:0]    q;
    rdc_pkg::rdc_digit_t new_digit;

    // quotient estimate and one correction step
    assign q_est  = prod_reg[rdc_pkg::PROD_W-1:rdc_pkg::RECIP_W];
    assign qb     = {{RW{1'b0}}, q_est} * {{VW{1'b0}}, base_reg};
    assign r_full = {{RW{1'b0}}, v_reg} - qb;
    assign rem5   = r_full[RW:0];
    assign fix    = (rem5 >= {1'b0, base_reg});
    assign dig5   = fix ? (rem5 - {1'b0, base_reg}) : rem5;
    assign q      = q_est + VW'(fix);

    assign new_digit.digit      = dig5[rdc_pkg::DIGIT_W-1:0];
    assign new_digit.group_mark = (phase_reg == '0);

    assign out_count  = n_reg;
    assign out_digits = vec_reg;

    always_comb begin
        state_next = state_reg;
        v_next     = v_reg;
        base_next  = base_reg;
        prod_next  = prod_reg;
        n_next     = n_reg;
        phase_next = phase_reg;
        vec_next   = vec_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            rdc_pkg::F_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    v_next     = in_value;
                    base_next  = rdc_pkg::eff_radix(radix);
                    n_next     = '0;
                    phase_next = '0;
                    state_next = rdc_pkg::F_MUL;
                end
            end
            rdc_pkg::F_MUL: begin
                prod_next  = rdc_pkg::PROD_W'(v_reg) *
                             rdc_pkg::PROD_W'(rdc_pkg::recip(base_reg));
                state_next = rdc_pkg::F_FIX;
            end
            rdc_pkg::F_FIX: begin
                // newest digit enters at the top, so the top is the msd
                vec_next   = {new_digit, vec_reg[VEC_W-1:DG_W]};
                n_next     = n_reg + 1'b1;
                v_next     = q;
                phase_next = (phase_reg == PW'(GROUP_SIZE - 1)) ? '0 : phase_reg + 1'b1;
                if ((q == '0) || (n_reg == CW'(MAX_DIGITS - 1))) begin
                    state_next = rdc_pkg::F_PUSH;
                end else begin
                    state_next = rdc_pkg::F_MUL;
                end
            end
            rdc_pkg::F_PUSH: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    state_next = rdc_pkg::F_IDLE;
                end
            end
            default: begin
                state_next = rdc_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rdc_pkg::F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        v_reg     <= v_next;
        base_reg  <= base_next;
        prod_reg  <= prod_next;
        n_reg     <= n_next;
        phase_reg <= phase_next;
        vec_reg   <= vec_next;
    end

endmodule

// ===== rtl/rdc_queue.sv =====
// two-entry queue of converted items between front and back end
// depends on nothing
module rdc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/rdc_back.sv =====
// back end: emits the digits of one item most significant first
// depends on rdc_pkg
module rdc_back #(
    parameter int MAX_DIGITS = 32,
    localparam int CW    = $clog2(MAX_DIGITS + 1),
    localparam int DG_W  = $bits(rdc_pkg::rdc_digit_t),
    localparam int VEC_W = MAX_DIGITS * DG_W
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [CW-1:0]                 q_count,
    input  logic [VEC_W-1:0]              q_digits,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]   m_digit,
    output logic                          m_group_mark,
    output logic                          m_last
);

    logic [CW-1:0]                 rem_reg, rem_next;
    logic [VEC_W-1:0]              vec_reg, vec_next;
    logic                          valid_reg, valid_next;
    logic [rdc_pkg::DIGIT_W-1:0]   digit_reg, digit_next;
    logic                          mark_reg, mark_next;
    logic                          last_reg, last_next;
    logic                          emit;
    rdc_pkg::rdc_digit_t           top;

    assign top     = vec_reg[VEC_W-1 -: DG_W];
    assign q_ready = (rem_reg == '0);
    assign emit    = (~valid_reg | m_ready) & (rem_reg != '0);

    assign m_valid      = valid_reg;
    assign m_digit      = digit_reg;
    assign m_group_mark = mark_reg;
    assign m_last       = last_reg;

    always_comb begin
        rem_next   = rem_reg;
        vec_next   = vec_reg;
        valid_next = valid_reg;
        digit_next = digit_reg;
        mark_next  = mark_reg;
        last_next  = last_reg;
        if (q_valid && q_ready) begin
            rem_next = q_count;
            vec_next = q_digits;
        end else if (emit) begin
            rem_next = rem_reg - 1'b1;
            vec_next = vec_reg << DG_W;
        end
        if (emit) begin
            valid_next = 1'b1;
            digit_next = top.digit;
            mark_next  = top.group_mark;
            last_next  = (rem_reg == CW'(1));
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
        vec_reg   <= vec_next;
        digit_reg <= digit_next;
        mark_reg  <= mark_next;
        last_reg  <= last_next;
    end

endmodule

// ===== rtl/radix_digit_converter.sv =====
// radix digit converter: takes one 31-bit non-negative value per transfer and
// returns its digits in the base held by the radix register (2..10; smaller
// values act as 2, larger as 10), one result transfer per digit, most
// significant first. group_mark is set when the digit's position, counted from
// the least significant digit as 0, is a multiple of GROUP_SIZE; last is set on
// the least significant digit. zero gives the single digit 0. the front end
// spends one state in the reciprocal multiplier and one in the quotient
// correction on each digit. the back end runs behind a two-entry queue, so
// output stalls only hold up the front once the queue is full. the radix
// register sits at byte address 0 of the apb port and is sampled when a value
// is accepted.
// depends on rdc_pkg, rdc_front, rdc_queue, rdc_back
module radix_digit_converter #(
    parameter int MAX_DIGITS = 32,
    parameter int GROUP_SIZE = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input channel
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rdc_pkg::VALUE_W-1:0]   s_value,
    // result channel
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rdc_pkg::DIGIT_W-1:0]   m_digit,
    output logic                          m_group_mark,
    output logic                          m_last,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CW    = $clog2(MAX_DIGITS + 1);
    localparam int VEC_W = MAX_DIGITS * $bits(rdc_pkg::rdc_digit_t);
    localparam int QW    = CW + VEC_W;

    logic [rdc_pkg::RADIX_W-1:0] radix_reg, radix_next;
    logic                        cfg_wr;

    // front to queue
    logic             f_valid;
    logic             f_ready;
    logic [CW-1:0]    f_count;
    logic [VEC_W-1:0] f_digits;

    // queue to back
    logic             b_valid;
    logic             b_ready;
    logic [QW-1:0]    b_data;

    // apb register: one 32-bit word, low nibble holds the radix
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[2] == rdc_pkg::REG_RADIX);
    assign prdata = (paddr[2] == rdc_pkg::REG_RADIX) ? {28'd0, radix_reg} : 32'd0;

    always_comb begin
        radix_next = radix_reg;
        if (cfg_wr) begin
            radix_next = pwdata[rdc_pkg::RADIX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg <= rdc_pkg::RADIX_RESET;
        end else begin
            radix_reg <= radix_next;
        end
    end

    // conversion: a multiply state and a correction state per digit
    rdc_front #(
        .MAX_DIGITS (MAX_DIGITS),
        .GROUP_SIZE (GROUP_SIZE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_value   (s_value),
        .radix      (radix_reg),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_count  (f_count),
        .out_digits (f_digits)
    );

    // converted items wait here for the back end
    rdc_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_count, f_digits}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    // emission: one digit per cycle into the output register while the output is not stalled
    rdc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (b_valid),
        .q_ready      (b_ready),
        .q_count      (b_data[QW-1:VEC_W]),
        .q_digits     (b_data[VEC_W-1:0]),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit      (m_digit),
        .m_group_mark (m_group_mark),
        .m_last       (m_last)
    );

endmodule

// ===== rtl/rdc_checker.sv =====
// port-level checks for the radix digit converter, bound to the top level
// depends on rdc_pkg and radix_digit_converter
module rdc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [rdc_pkg::DIGIT_W-1:0] m_digit,
    input logic                        m_group_mark,
    input logic                        m_last
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_digit) &&
                                $stable(m_group_mark) && $stable(m_last))
        else $error("stalled result changed");

    // every digit is a decimal digit or less
    a_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit <= 4'd9))
        else $error("digit out of range");

    // position zero always starts a group
    a_last_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_group_mark)
        else $error("last digit without group mark");

    // the front end is busy right after taking a value
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while converting");

    // reset leaves no result pending
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_digit      (m_digit),
    .m_group_mark (m_group_mark),
    .m_last       (m_last)
);

// ===== tb/radix_digit_converter_tb.sv =====
// testbench for radix_digit_converter: streams values through the block under every base 2..10 and
// several clamped settings, and checks each digit transfer against a built-in digit predictor
// depends on rdc_pkg and the radix_digit_converter rtl
`timescale 1ns / 1ps

module radix_digit_converter_tb;

    import rdc_pkg::*;

    localparam int MAX_DIGITS       = 32;
    localparam int GROUP_SIZE       = 4;
    localparam int NUM_PHASES       = 15;
    localparam int RANDOM_PER_PHASE = 17;
    // settle time for the front end after the last value, with margin for the longest value
    localparam int SETTLE_CYCLES    = 70;
    localparam int LONG_HOLD        = 300;
    localparam int MAX_REPORTS      = 10;

    // one expected digit transfer
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               group_mark;
        logic               last;
    } digit_result_t;

    // clock, reset and all block inputs start at known values
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic [VALUE_W-1:0]   s_value      = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [DIGIT_W-1:0]   m_digit;
    logic                 m_group_mark;
    logic                 m_last;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [2:0]           paddr        = '0;
    logic [31:0]          pwdata       = '0;
    logic [31:0]          prdata;
    logic                 pready;

    // values waiting to be offered, and digits the block still owes us
    logic [VALUE_W-1:0]   values_to_send[$];
    digit_result_t        digits_due[$];

    // our copy of the radix register, only changed while the block is idle
    logic [RADIX_W-1:0]   radix_setting = RADIX_RESET;

    int unsigned          error_count   = 0;
    int unsigned          send_gap      = 0;
    int unsigned          stall_left    = 0;
    int unsigned          hold_left     = 0;
    int unsigned          hold_requests = 0;
    int unsigned          hold_served   = 0;
    // phases with no idling at all on one side
    bit                   send_steady   = 1'b0;
    bit                   recv_steady   = 1'b0;

    radix_digit_converter #(
        .MAX_DIGITS (MAX_DIGITS),
        .GROUP_SIZE (GROUP_SIZE)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_digit      (m_digit),
        .m_group_mark (m_group_mark),
        .m_last       (m_last),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // first few failures in detail, the rest only counted
    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS) begin
            $display("[%0t] %s", $realtime, msg);
        end
        error_count++;
    endtask

    // split a value into digits of the effective base and queue them
    // most significant first; out-of-range radix settings clamp to 2 or 10
    function automatic void predict_digits(input logic [VALUE_W-1:0] value,
                                           input logic [RADIX_W-1:0] setting);
        int unsigned        base;
        int unsigned        quotient;
        int unsigned        count;
        logic [DIGIT_W-1:0] held[MAX_DIGITS];
        digit_result_t      res;
        base = (setting < 2) ? 2 : ((setting > 10) ? 10 : setting);
        quotient = value;
        count = 0;
        // at least one digit, so zero gives a single 0
        do begin
            held[count] = DIGIT_W'(quotient % base);
            quotient = quotient / base;
            count++;
        end while (quotient != 0 && count < MAX_DIGITS);
        for (int pos = count - 1; pos >= 0; pos--) begin
            res.digit      = held[pos];
            res.group_mark = (pos % GROUP_SIZE) == 0;
            res.last       = (pos == 0);
            digits_due.push_back(res);
        end
    endfunction

    // random value of random bit length, with all-ones, single-bit and small-value shapes mixed in
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned len;
        int unsigned mask;
        int unsigned shape;
        len   = $urandom_range(1, VALUE_W);
        mask  = (32'h1 << len) - 1;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            return VALUE_W'(mask);
        end else if (shape == 1) begin
            return VALUE_W'(32'h1 << (len - 1));
        end else if (shape == 2) begin
            return VALUE_W'($urandom_range(0, 20));
        end
        return VALUE_W'($urandom & mask);
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_length();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(0, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // input driver: keeps valid and payload steady until the transfer happens,
    // predicts the digits of each accepted value
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                predict_digits(s_value, radix_setting);
            end
            // the slot is free when nothing is offered or the offer was just taken
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (values_to_send.size() > 0) begin
                    s_valid  <= 1'b1;
                    s_value  <= values_to_send.pop_front();
                    send_gap <= send_steady ? 0 : idle_length();
                end else begin
                    s_valid  <= 1'b0;
                end
            end
        end
    end

    // result ready: random stalls, plus a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            m_ready     <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!recv_steady && $urandom_range(0, 3) == 0) begin
            stall_left <= idle_length();
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor: every digit transfer must match the oldest expected digit
    always @(posedge aclk) begin
        digit_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (digits_due.size() == 0) begin
                report_error($sformatf("unexpected digit %0d mark %0b last %0b",
                                       m_digit, m_group_mark, m_last));
            end else begin
                want = digits_due.pop_front();
                if (m_digit !== want.digit || m_group_mark !== want.group_mark ||
                    m_last !== want.last) begin
                    report_error($sformatf(
                        "digit mismatch: want %0d mark %0b last %0b, got %0d mark %0b last %0b",
                        want.digit, want.group_mark, want.last,
                        m_digit, m_group_mark, m_last));
                end
            end
        end
    end

    // apb write of the radix register, then a back-to-back read to check it stuck
    task automatic set_radix(input logic [RADIX_W-1:0] setting);
        logic [31:0] word;
        word = $urandom;
        word[RADIX_W-1:0] = setting;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_RADIX, 2'b00};
        pwdata  <= word;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // the write lands at this edge; go straight into the read setup
        radix_setting = setting;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[RADIX_W-1:0] !== setting) begin
            report_error($sformatf("radix readback %0h, wrote %0h",
                                   prdata[RADIX_W-1:0], setting));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sender holds back until every owed digit has come, then lets the block settle
    // checked between edges so the driver's updates of the edge are already visible
    task automatic wait_until_drained();
        do begin
            @(negedge aclk);
        end while (values_to_send.size() != 0 || s_valid || digits_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // stimulus: one phase per radix setting, extremes and clamped codes included
    initial begin
        logic [RADIX_W-1:0] radix_plan[NUM_PHASES];
        logic [VALUE_W-1:0] binary_corners[10];
        logic [VALUE_W-1:0] decimal_corners[8];
        radix_plan = '{4'd2, 4'd10, 4'd0, 4'd15, 4'd1, 4'd11, 4'd13, 4'd5,
                       4'd3, 4'd7, 4'd9, 4'd4, 4'd6, 4'd8, 4'd12};
        // zero, tiny values, powers of the base and their neighbors, full range
        binary_corners  = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd15, 31'd16,
                            31'h7FFF_FFFF, 31'h4000_0000, 31'h5555_5555};
        decimal_corners = '{31'd0, 31'd9, 31'd10, 31'd9999, 31'd10000,
                            31'd999999999, 31'd1000000000, 31'd2147483647};

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // phase 0 runs on the reset radix
            if (p > 0) begin
                set_radix(radix_plan[p]);
            end
            send_steady = (p % 4 == 2);
            recv_steady = (p % 4 == 3);
            if (p == 0) begin
                foreach (binary_corners[i]) values_to_send.push_back(binary_corners[i]);
            end else if (p == 1) begin
                foreach (decimal_corners[i]) values_to_send.push_back(decimal_corners[i]);
            end
            // long receiver hold-off while values keep coming, so the block backs up
            if (p == 5) begin
                @(posedge aclk);
                hold_requests <= hold_requests + 1;
            end
            repeat (RANDOM_PER_PHASE) values_to_send.push_back(random_value());
            wait_until_drained();
        end

        if (digits_due.size() != 0) begin
            report_error($sformatf("%0d digits never arrived", digits_due.size()));
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #6_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rdc_pkg.sv
rtl/rdc_front.sv
rtl/rdc_queue.sv
rtl/rdc_back.sv
rtl/radix_digit_converter.sv
rtl/rdc_checker.sv
tb/radix_digit_converter_tb.sv
